// File: src/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types and codes for the bitmap run allocator: payload structs,
// mode, status and register codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bra_pkg;

    // Input item and result item
    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] run_length;
        logic [11:0] byte_address;
        logic [7:0]  byte_data;
    } t_alloc_in;

    typedef struct packed {
        logic [24:0] first_sector;
        logic [7:0]  map_byte;
        logic [1:0]  status;
    } t_alloc_out;

    // Item modes
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_CONFLICT = 2'd2;

    // Configuration register indexes and data width
    localparam int         CFG_DATA_W            = 24;
    localparam logic       CFG_MAP_BYTES_IN_USE  = 1'b0;
    localparam logic       CFG_FIRST_DATA_SECTOR = 1'b1;
    localparam int         CFG_USE_W             = 13;
    localparam int         SECTOR_W              = 25;

    // Result selection
    typedef enum logic [2:0] {
        RES_ZERO,
        RES_SECTOR,
        RES_FULL,
        RES_CONFLICT,
        RES_BYTE
    } t_res_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic     item_load;   // capture the accepted item
        logic     item_wr;     // write the item's byte into the map
        logic     item_rd;     // read the map byte at the item's address
        logic     clr_wr;      // write zero at the sweep address and advance
        logic     addr_zero;   // restart the sweep at byte zero
        logic     take_start;  // latch run start from the hit byte
        logic     addr_start;  // restart the sweep at the run's first byte
        logic     rd_issue;    // read at the sweep address and advance
        logic     mark_wr;     // write back the returned byte with run bits set
        logic     res_en;      // present a result
        t_res_sel res_sel;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       len_zero;
        logic       len_big;
        logic       limit_zero;
        logic       clr_last;
        logic       addr_lt_limit;
        logic       addr_le_end;
        logic       scan_hit;
        logic       tag_last;
        logic       tag_over;
        logic       tag_used;
        logic       tag_at_end;
    } t_sts;

endpackage

// File: src/bra_dp.sv
// ----------------------------------------------------------------------------
// bra_dp
// Datapath: map store, sweep address and read tag pipeline, run bounds,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module bra_dp import bra_pkg::*; #(
    parameter int MAP_BYTES = 4096,
    parameter int MAX_RUN   = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_alloc_in             i_item,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_done,
    output t_alloc_out            o_result
);

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int LW = $clog2(MAP_BYTES + 1);
    localparam int PW = $clog2(MAP_BYTES * 8 + MAX_RUN + 16);
    localparam int BW = PW - 3;
    localparam int LIMIT_RST = (MAP_BYTES < 4096) ? MAP_BYTES : 4096;

    // Lowest clear bit of a byte
    function automatic logic [2:0] low_zero(input logic [7:0] b);
        logic [2:0] k;
        k = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!b[i]) begin
                k = 3'(i);
            end
        end
        return k;
    endfunction

    logic [7:0]    r_mem [MAP_BYTES];
    logic [7:0]    r_rdata;
    t_alloc_in     r_item;
    logic [LW-1:0] r_limit;
    logic [23:0]   r_fds;
    logic [BW-1:0] r_addr;
    logic [BW-1:0] r_tag;
    logic          r_tag_vld;
    logic [PW-1:0] r_start;
    logic [PW-1:0] r_end;
    logic          r_done;
    t_alloc_out    r_result;

    logic [PW-1:0] n_start;
    logic [BW-1:0] start_byte;
    logic [BW-1:0] end_byte;
    logic [2:0]    lo_bit;
    logic [2:0]    hi_bit;
    logic [7:0]    run_mask;
    logic          addr_ok;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [CFG_USE_W-1:0] cfg_use;
    t_alloc_out    n_result;

    assign start_byte = r_start[PW-1:3];
    assign end_byte   = r_end[PW-1:3];
    assign addr_ok    = 32'(r_item.byte_address) < 32'(MAP_BYTES);
    assign n_start    = {r_tag, low_zero(r_rdata)};
    assign cfg_use    = i_cfg_data[CFG_USE_W-1:0];

    // Bits of the run that fall in the tagged byte
    always_comb begin
        lo_bit   = (r_tag == start_byte) ? r_start[2:0] : 3'd0;
        hi_bit   = (r_tag == end_byte) ? r_end[2:0] : 3'd7;
        run_mask = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));
    end

    // Status toward the controller
    always_comb begin
        o_sts.mode          = r_item.mode;
        o_sts.len_zero      = (r_item.run_length == 12'd0);
        o_sts.len_big       = 32'(r_item.run_length) > 32'(MAX_RUN);
        o_sts.limit_zero    = (r_limit == '0);
        o_sts.clr_last      = (32'(r_addr) == 32'(MAP_BYTES - 1));
        o_sts.addr_lt_limit = 32'(r_addr) < 32'(r_limit);
        o_sts.addr_le_end   = (r_addr <= end_byte);
        o_sts.scan_hit      = r_tag_vld && (r_rdata != 8'hFF);
        o_sts.tag_last      = r_tag_vld && (32'(r_tag) == 32'(r_limit) - 32'd1);
        o_sts.tag_over      = r_tag_vld && (32'(r_tag) >= 32'(r_limit));
        o_sts.tag_used      = r_tag_vld && ((r_rdata & run_mask) != 8'd0);
        o_sts.tag_at_end    = r_tag_vld && (r_tag == end_byte);
    end

    // Select the map port addresses and data
    always_comb begin
        rd_en   = i_cmd.item_rd | i_cmd.rd_issue;
        rd_addr = i_cmd.item_rd ? AW'(r_item.byte_address) : r_addr[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_addr[AW-1:0];
        wr_data = 8'd0;
        if (i_cmd.clr_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.item_wr) begin
            wr_en   = addr_ok;
            wr_addr = AW'(r_item.byte_address);
            wr_data = r_item.byte_data;
        end else if (i_cmd.mark_wr) begin
            wr_en   = r_tag_vld;
            wr_addr = r_tag[AW-1:0];
            wr_data = r_rdata | run_mask;
        end
    end

    // Map store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Build the result
    always_comb begin
        n_result = '0;
        case (i_cmd.res_sel)
            RES_ZERO: begin
                n_result.status = STATUS_OK;
            end
            RES_SECTOR: begin
                n_result.first_sector = SECTOR_W'(r_start) + SECTOR_W'(r_fds)
                                      - SECTOR_W'(1);
                n_result.status       = STATUS_OK;
            end
            RES_FULL: begin
                n_result.status = STATUS_FULL;
            end
            RES_CONFLICT: begin
                n_result.status = STATUS_CONFLICT;
            end
            RES_BYTE: begin
                n_result.map_byte = addr_ok ? r_rdata : 8'd0;
            end
            default: begin
                n_result = '0;
            end
        endcase
    end

    // Payload registers: item, run bounds, tag, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_item <= i_item;
        end
        if (i_cmd.take_start) begin
            r_start <= n_start;
            r_end   <= n_start + PW'(r_item.run_length) - PW'(1);
        end
        if (i_cmd.rd_issue) begin
            r_tag <= r_addr;
        end
        if (i_cmd.res_en) begin
            r_result <= n_result;
        end
    end

    // Control registers: sweep address, tag valid, strobe, configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_tag_vld <= 1'b0;
            r_done    <= 1'b0;
            r_limit   <= LW'(LIMIT_RST);
            r_fds     <= 24'd1;
        end else begin
            r_tag_vld <= i_cmd.rd_issue;
            r_done    <= i_cmd.res_en;
            if (i_cmd.addr_zero) begin
                r_addr <= '0;
            end else if (i_cmd.take_start) begin
                r_addr <= r_tag;
            end else if (i_cmd.addr_start) begin
                r_addr <= start_byte;
            end else if (i_cmd.rd_issue || i_cmd.clr_wr) begin
                r_addr <= r_addr + BW'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAP_BYTES_IN_USE: begin
                        r_limit <= (32'(cfg_use) > 32'(MAP_BYTES)) ? LW'(MAP_BYTES)
                                                                  : LW'(cfg_use);
                    end
                    CFG_FIRST_DATA_SECTOR: begin
                        r_fds <= i_cfg_data[23:0];
                    end
                    default: begin
                        r_fds <= r_fds;
                    end
                endcase
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: src/bra_ctrl.sv
// ----------------------------------------------------------------------------
// bra_ctrl
// Controller: clearing pass after reset, item dispatch, and the scan, check
// and mark sweeps of an allocation.
// ----------------------------------------------------------------------------
module bra_ctrl import bra_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output logic busy,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RDRESP,
        S_SCAN,
        S_CHECK,
        S_MARK
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.addr_zero = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.item_load = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (i_sts.mode)
                    MODE_LOAD: begin
                        o_cmd.item_wr = 1'b1;
                        o_cmd.res_en  = 1'b1;
                        o_cmd.res_sel = RES_ZERO;
                    end
                    MODE_READ: begin
                        o_cmd.item_rd = 1'b1;
                        n_state       = S_RDRESP;
                    end
                    MODE_ALLOC: begin
                        if (i_sts.len_zero) begin
                            o_cmd.res_en  = 1'b1;
                            o_cmd.res_sel = RES_ZERO;
                        end else if (i_sts.len_big || i_sts.limit_zero) begin
                            o_cmd.res_en  = 1'b1;
                            o_cmd.res_sel = RES_FULL;
                        end else begin
                            o_cmd.addr_zero = 1'b1;
                            n_state         = S_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.res_en  = 1'b1;
                        o_cmd.res_sel = RES_ZERO;
                    end
                endcase
            end
            S_RDRESP: begin
                o_cmd.res_en  = 1'b1;
                o_cmd.res_sel = RES_BYTE;
                n_state       = S_IDLE;
            end
            // Find the first byte with a clear bit
            S_SCAN: begin
                if (i_sts.scan_hit) begin
                    o_cmd.take_start = 1'b1;
                    n_state          = S_CHECK;
                end else if (i_sts.tag_last) begin
                    o_cmd.res_en  = 1'b1;
                    o_cmd.res_sel = RES_FULL;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_issue = i_sts.addr_lt_limit;
                end
            end
            // Walk the run's bytes upward for end of map or a used bit
            S_CHECK: begin
                if (i_sts.tag_over) begin
                    o_cmd.res_en  = 1'b1;
                    o_cmd.res_sel = RES_FULL;
                    n_state       = S_IDLE;
                end else if (i_sts.tag_used) begin
                    o_cmd.res_en  = 1'b1;
                    o_cmd.res_sel = RES_CONFLICT;
                    n_state       = S_IDLE;
                end else if (i_sts.tag_at_end) begin
                    o_cmd.addr_start = 1'b1;
                    n_state          = S_MARK;
                end else begin
                    o_cmd.rd_issue = i_sts.addr_le_end;
                end
            end
            // Read, set run bits, write back
            S_MARK: begin
                o_cmd.mark_wr = 1'b1;
                if (i_sts.tag_at_end) begin
                    o_cmd.res_en  = 1'b1;
                    o_cmd.res_sel = RES_SECTOR;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_issue = i_sts.addr_le_end;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: src/bitmap_run_allocator_core.sv
// From start to o_done: load and read capture the item, then write or read the
// map byte and present the result; allocate scans, checks and marks, each sweep
// moving one map byte per cycle through the single map read port.
// Throughput: one item at a time; busy stays high until the result transfer.
// Reset: after i_rst_n a clearing pass writes zero to all MAP_BYTES map bytes,
// one per cycle, with busy high; the receiver cannot stall o_done.
// ----------------------------------------------------------------------------
// bitmap_run_allocator_core
// Run allocator over a free-space bitmap of sectors: load and read
// map bytes, and allocate contiguous runs from the lowest free bit.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_core import bra_pkg::*; #(
    parameter int MAP_BYTES = 4096,
    parameter int MAX_RUN   = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    input  t_alloc_in             i_item,
    output logic                  busy,
    output logic                  o_done,
    output t_alloc_out            o_result
);

    t_cmd cmd;
    t_sts sts;

    // Sequence the item
    bra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // Map store and arithmetic
    bra_dp #(
        .MAP_BYTES (MAP_BYTES),
        .MAX_RUN   (MAX_RUN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule
